// ----- hw/rtl/ang_pkg.sv -----
// ----------------------------------------------------------------------------
// ang_pkg
// Shared widths, register indexes, reset values and types of the audio noise
// gate.
// ----------------------------------------------------------------------------
package ang_pkg;

   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 24;
   localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int COEF_BITS     = 24;
   localparam int LEVEL_BITS    = 23;
   localparam int HOLD_BITS     = 18;
   localparam int MIX_BITS      = 17;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   // -60 dB attenuation as a Q0.24 multiplier.
   localparam int ATTEN_BITS  = 15;
   localparam int ATTEN_SHIFT = 24;
   localparam logic [ATTEN_BITS-1:0] ATTEN_Q24 = 15'd16777;

   localparam int MIX_SHIFT = 16;
   localparam logic [MIX_BITS-1:0] MIX_ONE = 17'h10000;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLOSE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OPEN    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIX     = 3'd5;

   localparam logic [COEF_BITS-1:0]  RST_ATTACK  = 24'd16707456;
   localparam logic [COEF_BITS-1:0]  RST_RELEASE = 24'd16773721;
   localparam logic [LEVEL_BITS-1:0] RST_CLOSE   = 23'd26527;
   localparam logic [LEVEL_BITS-1:0] RST_OPEN    = 23'd37470;
   localparam logic [HOLD_BITS-1:0]  RST_HOLD    = 18'd2400;
   localparam logic [MIX_BITS-1:0]   RST_MIX     = 17'd65536;

   typedef struct packed {
      logic [COEF_BITS-1:0]  attack_coeff;
      logic [COEF_BITS-1:0]  release_coeff;
      logic [LEVEL_BITS-1:0] close_level;
      logic [LEVEL_BITS-1:0] open_level;
      logic [HOLD_BITS-1:0]  hold_count;
      logic [MIX_BITS-1:0]   mix_level;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] env;
      logic                   is_open;
      logic [HOLD_BITS-1:0]   hold;
   } chan_state_type;

endpackage

// ----- hw/rtl/ang_chan_update.sv -----
// ----------------------------------------------------------------------------
// ang_chan_update
// Envelope follower, gate state update and wet signal for one sample.
// ----------------------------------------------------------------------------
module ang_chan_update (
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] sample,
   input  ang_pkg::chan_state_type                state_cur,
   input  ang_pkg::cfg_type                       cfg,
   output ang_pkg::chan_state_type                state_nxt,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] wet
);

   localparam int SB        = ang_pkg::SAMPLE_BITS;
   localparam int CB        = ang_pkg::COEF_BITS;
   localparam int PROD_BITS = SB + CB + 2;
   localparam int ATT_BITS  = SB + ang_pkg::ATTEN_BITS;
   localparam int CMP_BITS  = (SB > ang_pkg::LEVEL_BITS) ? SB : ang_pkg::LEVEL_BITS;
   localparam logic signed [PROD_BITS-1:0] ENV_HALF = $signed(PROD_BITS'(1) << (CB - 1));
   localparam logic [ATT_BITS-1:0] ATT_HALF = ATT_BITS'(1) << (ang_pkg::ATTEN_SHIFT - 1);

   logic                        neg;
   logic [SB-1:0]               mag;
   logic [CB-1:0]               coef;
   logic signed [SB:0]          diff;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] step;
   logic signed [SB+1:0]        env_sum;
   logic [SB-1:0]               env_new;
   logic [CMP_BITS-1:0]         env_cmp;
   logic [CMP_BITS-1:0]         close_cmp;
   logic [CMP_BITS-1:0]         open_cmp;
   logic [ATT_BITS-1:0]         att_prod;
   logic [ATT_BITS-1:0]         att_rnd;
   logic [SB-1:0]               att_mag;

   assign neg = sample[SB-1];
   assign mag = neg ? SB'(~$unsigned(sample) + 1'b1) : $unsigned(sample);

   // env' = mag + floor(((env - mag) * c + half) / 2^24), the rounded one-pole
   // blend written with a single multiplication.
   assign coef    = (mag > state_cur.env) ? cfg.attack_coeff : cfg.release_coeff;
   assign diff    = $signed({1'b0, state_cur.env}) - $signed({1'b0, mag});
   assign prod    = diff * $signed({1'b0, coef});
   assign step    = (prod + ENV_HALF) >>> CB;
   assign env_sum = $signed({2'b00, mag}) + $signed(step[SB+1:0]);
   assign env_new = env_sum[SB-1:0];

   assign env_cmp   = CMP_BITS'(env_new);
   assign close_cmp = CMP_BITS'(cfg.close_level);
   assign open_cmp  = CMP_BITS'(cfg.open_level);

   always_comb begin
      state_nxt.env     = env_new;
      state_nxt.is_open = state_cur.is_open;
      state_nxt.hold    = state_cur.hold;
      if (state_cur.is_open) begin
         if (state_cur.hold != '0) begin
            state_nxt.hold = state_cur.hold - 1'b1;
         end else if (env_cmp < close_cmp) begin
            state_nxt.is_open = 1'b0;
         end
      end else if (env_cmp > open_cmp) begin
         state_nxt.is_open = 1'b1;
         state_nxt.hold    = cfg.hold_count;
      end
   end

   // Attenuation rounds the magnitude, so the result is half away from zero.
   assign att_prod = ATT_BITS'(mag) * ATT_BITS'(ang_pkg::ATTEN_Q24);
   assign att_rnd  = att_prod + ATT_HALF;
   assign att_mag  = SB'(att_rnd >> ang_pkg::ATTEN_SHIFT);

   always_comb begin
      if (state_cur.is_open) begin
         wet = sample;
      end else if (neg) begin
         wet = $signed(SB'(~att_mag + 1'b1));
      end else begin
         wet = $signed(att_mag);
      end
   end

endmodule

// ----- hw/rtl/ang_mix.sv -----
// ----------------------------------------------------------------------------
// ang_mix
// Dry and wet blend by the mix level, rounding and saturation.
// ----------------------------------------------------------------------------
module ang_mix (
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] dry,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] wet,
   input  logic [ang_pkg::MIX_BITS-1:0]           mix_level,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] mixed
);

   localparam int SB       = ang_pkg::SAMPLE_BITS;
   localparam int MS       = ang_pkg::MIX_SHIFT;
   localparam int ACC_BITS = SB + ang_pkg::MIX_BITS + 3;
   localparam logic [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (MS - 1);
   localparam logic signed [ACC_BITS-1:0] Y_HI = $signed((ACC_BITS'(1) << (SB - 1)) - 1'b1);
   localparam logic signed [ACC_BITS-1:0] Y_LO = -Y_HI - 1;

   logic [ang_pkg::MIX_BITS-1:0] m;
   logic signed [SB:0]           dw;
   logic signed [ACC_BITS-1:0]   dry_ext;
   logic signed [ACC_BITS-1:0]   acc;
   logic                         neg;
   logic [ACC_BITS-1:0]          amag;
   logic [ACC_BITS-1:0]          rmag;
   logic signed [ACC_BITS-1:0]   y_full;

   // acc = dry * (1 - m) + wet * m, rearranged around one multiplication.
   assign m       = (mix_level > ang_pkg::MIX_ONE) ? ang_pkg::MIX_ONE : mix_level;
   assign dw      = wet - dry;
   assign dry_ext = dry;
   assign acc     = (dry_ext <<< MS) + dw * $signed({1'b0, m});

   assign neg    = acc[ACC_BITS-1];
   assign amag   = neg ? (~$unsigned(acc) + 1'b1) : $unsigned(acc);
   assign rmag   = (amag + ACC_HALF) >> MS;
   assign y_full = neg ? $signed(~rmag + 1'b1) : $signed(rmag);

   always_comb begin
      if (y_full > Y_HI) begin
         mixed = $signed(Y_HI[SB-1:0]);
      end else if (y_full < Y_LO) begin
         mixed = $signed(Y_LO[SB-1:0]);
      end else begin
         mixed = $signed(y_full[SB-1:0]);
      end
   end

endmodule

// ----- hw/rtl/audio_noise_gate.sv -----
// ----------------------------------------------------------------------------
// audio_noise_gate
// Per-channel noise gate with hysteresis and hold, followed by a dry/wet mix.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_ready   req_chan, req_sample_in
//   rsp       out        rsp_valid/rsp_ready   rsp_sample_out, rsp_gate_is_open
//   csr       in         csr_we (no wait)      csr_index, csr_wdata
//
// The block takes one item per cycle and holds that rate for as long as the
// result side takes results. Each item passes three registers: the input
// register, the mid register after the envelope and gate update, and the
// result register after the mix. The per-channel state is read and written
// back in the first stage in the same cycle, which lets items of the same
// channel follow each other without a gap. Reset is synchronous and active
// high; it closes every gate, clears envelopes and hold counters and loads
// the register defaults. A stall on the result side fills empty stages
// first, so the input stays ready until all three stages hold an item.
//
module audio_noise_gate (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_chan,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0]    req_sample_in,

   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                                      rsp_gate_is_open,

   input  logic                                      csr_we,
   input  logic [ang_pkg::CSR_IDX_BITS-1:0]          csr_index,
   input  logic [ang_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);

   localparam int SB = ang_pkg::SAMPLE_BITS;

   // Configuration registers.
   ang_pkg::cfg_type cfg_ff;
   ang_pkg::cfg_type cfg_in;

   // Per-channel gate state: envelope, open flag and hold counter.
   ang_pkg::chan_state_type chan_ff [ang_pkg::CHANNELS];

   // Stage valid bits.
   logic s1_v_ff, s2_v_ff, s3_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in;

   // Stage payloads.
   logic                 s1_ch_ff;
   logic signed [SB-1:0] s1_x_ff;
   logic signed [SB-1:0] s2_x_ff;
   logic signed [SB-1:0] s2_wet_ff;
   logic                 s2_open_ff;
   logic signed [SB-1:0] s3_y_ff;
   logic                 s3_open_ff;

   // Stage advance conditions: a stage loads when it is empty or when its
   // content moves on in the same cycle.
   logic s1_load, s2_load, s3_load;
   logic s1_fire;

   logic [ang_pkg::CH_BITS-1:0] s1_idx;
   ang_pkg::chan_state_type     state_cur;
   ang_pkg::chan_state_type     state_nxt;
   logic signed [SB-1:0]        s1_wet;
   logic signed [SB-1:0]        s2_mixed;

   assign s3_load   = !s3_v_ff || rsp_ready;
   assign s2_load   = !s2_v_ff || s3_load;
   assign s1_load   = !s1_v_ff || s2_load;
   assign s1_fire   = s1_v_ff && s2_load;
   assign req_ready = s1_load;

   assign s1_v_in = s1_load ? req_valid : s1_v_ff;
   assign s2_v_in = s2_load ? s1_v_ff   : s2_v_ff;
   assign s3_v_in = s3_load ? s2_v_ff   : s3_v_ff;

   // The channel number wraps onto the channels that exist.
   assign s1_idx    = (ang_pkg::CHANNELS == 1) ? '0 : ang_pkg::CH_BITS'(s1_ch_ff);
   assign state_cur = chan_ff[s1_idx];

   ang_chan_update u_chan_update (
      .sample    (s1_x_ff),
      .state_cur (state_cur),
      .cfg       (cfg_ff),
      .state_nxt (state_nxt),
      .wet       (s1_wet)
   );

   ang_mix u_mix (
      .dry       (s2_x_ff),
      .wet       (s2_wet_ff),
      .mix_level (cfg_ff.mix_level),
      .mixed     (s2_mixed)
   );

   // Register writes outside the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ang_pkg::CSR_ATTACK: begin
               cfg_in.attack_coeff = csr_wdata[ang_pkg::COEF_BITS-1:0];
            end
            ang_pkg::CSR_RELEASE: begin
               cfg_in.release_coeff = csr_wdata[ang_pkg::COEF_BITS-1:0];
            end
            ang_pkg::CSR_CLOSE: begin
               cfg_in.close_level = csr_wdata[ang_pkg::LEVEL_BITS-1:0];
            end
            ang_pkg::CSR_OPEN: begin
               cfg_in.open_level = csr_wdata[ang_pkg::LEVEL_BITS-1:0];
            end
            ang_pkg::CSR_HOLD: begin
               cfg_in.hold_count = csr_wdata[ang_pkg::HOLD_BITS-1:0];
            end
            ang_pkg::CSR_MIX: begin
               cfg_in.mix_level = csr_wdata[ang_pkg::MIX_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff  <= ang_pkg::RST_ATTACK;
         cfg_ff.release_coeff <= ang_pkg::RST_RELEASE;
         cfg_ff.close_level   <= ang_pkg::RST_CLOSE;
         cfg_ff.open_level    <= ang_pkg::RST_OPEN;
         cfg_ff.hold_count    <= ang_pkg::RST_HOLD;
         cfg_ff.mix_level     <= ang_pkg::RST_MIX;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         for (int i = 0; i < ang_pkg::CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
      end else begin
         cfg_ff  <= cfg_in;
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         // The channel state updates as its item leaves the first stage, so
         // the next item in the input register already sees it.
         if (s1_fire) begin
            chan_ff[s1_idx] <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_ch_ff <= req_chan;
         s1_x_ff  <= req_sample_in;
      end
      if (s1_fire) begin
         s2_x_ff    <= s1_x_ff;
         s2_wet_ff  <= s1_wet;
         s2_open_ff <= state_nxt.is_open;
      end
      if (s3_load && s2_v_ff) begin
         s3_y_ff    <= s2_mixed;
         s3_open_ff <= s2_open_ff;
      end
   end

   assign rsp_valid        = s3_v_ff;
   assign rsp_sample_out   = s3_y_ff;
   assign rsp_gate_is_open = s3_open_ff;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for audio_noise_gate. A scoreboard class models the
// per-channel envelope, gate and dry/wet mix, and checks every output item in
// order, while plain tasks drive samples and register writes under several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

   // Codes outside the register list; writes to them must be ignored.
   localparam logic [ang_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ang_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint SAMPLE_MAX     = (longint'(1) << (ang_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
   localparam int     QUIET_LIMIT    = 1000;
   localparam int     RANDOM_PHASES  = 10;
   localparam int     PHASE_ITEMS    = 88;
   localparam int     MAX_REPORTS    = 10;
   localparam int     DRAIN_CYCLES   = 10;

   typedef struct packed {
      logic signed [ang_pkg::SAMPLE_BITS-1:0] sample;
      logic                                   gate_open;
   } gate_output_type;

   // Holds a private copy of the registers and the channel state, predicts
   // the output of every accepted sample and compares it with what the block
   // delivers, oldest first.
   class gate_scoreboard;
      logic [ang_pkg::COEF_BITS-1:0]   attack_coeff;
      logic [ang_pkg::COEF_BITS-1:0]   release_coeff;
      logic [ang_pkg::LEVEL_BITS-1:0]  close_level;
      logic [ang_pkg::LEVEL_BITS-1:0]  open_level;
      logic [ang_pkg::HOLD_BITS-1:0]   hold_count;
      logic [ang_pkg::MIX_BITS-1:0]    mix_level;
      logic [ang_pkg::SAMPLE_BITS-1:0] env_level [ang_pkg::CHANNELS];
      logic                            gate_open [ang_pkg::CHANNELS];
      logic [ang_pkg::HOLD_BITS-1:0]   hold_left [ang_pkg::CHANNELS];
      gate_output_type                 pending_outputs [$];
      int                              mismatches;

      function new();
         attack_coeff  = ang_pkg::RST_ATTACK;
         release_coeff = ang_pkg::RST_RELEASE;
         close_level   = ang_pkg::RST_CLOSE;
         open_level    = ang_pkg::RST_OPEN;
         hold_count    = ang_pkg::RST_HOLD;
         mix_level     = ang_pkg::RST_MIX;
         for (int i = 0; i < ang_pkg::CHANNELS; i++) begin
            env_level[i] = '0;
            gate_open[i] = 1'b0;
            hold_left[i] = '0;
         end
         mismatches = 0;
      endfunction

      function void set_register(logic [ang_pkg::CSR_IDX_BITS-1:0] idx,
                                 logic [ang_pkg::CSR_DATA_BITS-1:0] val);
         case (idx)
            ang_pkg::CSR_ATTACK:  attack_coeff  = val[ang_pkg::COEF_BITS-1:0];
            ang_pkg::CSR_RELEASE: release_coeff = val[ang_pkg::COEF_BITS-1:0];
            ang_pkg::CSR_CLOSE:   close_level   = val[ang_pkg::LEVEL_BITS-1:0];
            ang_pkg::CSR_OPEN:    open_level    = val[ang_pkg::LEVEL_BITS-1:0];
            ang_pkg::CSR_HOLD:    hold_count    = val[ang_pkg::HOLD_BITS-1:0];
            ang_pkg::CSR_MIX:     mix_level     = val[ang_pkg::MIX_BITS-1:0];
            default:              ;
         endcase
      endfunction

      // Divide by 2^shift, rounding to nearest with ties away from zero.
      function longint round_half_away(longint v, int shift);
         longint unsigned mag;
         longint unsigned q;
         mag = (v < 0) ? -v : v;
         q = (mag + (64'd1 << (shift - 1))) >> shift;
         return (v < 0) ? -longint'(q) : longint'(q);
      endfunction

      function void note_input(logic [ang_pkg::CH_BITS-1:0] ch,
                               logic signed [ang_pkg::SAMPLE_BITS-1:0] s);
         longint          x;
         longint          wet;
         longint          m;
         longint          acc;
         longint          y;
         longint unsigned mag;
         longint unsigned c;
         longint unsigned env_new;
         gate_output_type o;
         x = s;
         mag = (x < 0) ? -x : x;
         c = (mag > env_level[ch]) ? attack_coeff : release_coeff;
         env_new = (mag * ((64'd1 << ang_pkg::COEF_BITS) - c) + env_level[ch] * c
                    + (64'd1 << (ang_pkg::COEF_BITS - 1))) >> ang_pkg::COEF_BITS;
         env_level[ch] = env_new[ang_pkg::SAMPLE_BITS-1:0];

         // The wet path uses the gate state from before this sample.
         if (gate_open[ch])
            wet = x;
         else
            wet = round_half_away(x * longint'(ang_pkg::ATTEN_Q24), ang_pkg::ATTEN_SHIFT);

         m = (mix_level > ang_pkg::MIX_ONE) ? longint'(ang_pkg::MIX_ONE)
                                            : longint'(mix_level);
         acc = x * (longint'(ang_pkg::MIX_ONE) - m) + wet * m;
         y = round_half_away(acc, ang_pkg::MIX_SHIFT);
         if (y > SAMPLE_MAX) y = SAMPLE_MAX;
         if (y < SAMPLE_MIN) y = SAMPLE_MIN;

         if (gate_open[ch]) begin
            if (hold_left[ch] != '0)
               hold_left[ch] = hold_left[ch] - 1'b1;
            else if (env_new < close_level)
               gate_open[ch] = 1'b0;
         end else if (env_new > open_level) begin
            gate_open[ch] = 1'b1;
            hold_left[ch] = hold_count;
         end

         o.sample    = y[ang_pkg::SAMPLE_BITS-1:0];
         o.gate_open = gate_open[ch];
         pending_outputs.push_back(o);
      endfunction

      function void check_result(logic signed [ang_pkg::SAMPLE_BITS-1:0] s, logic g);
         gate_output_type want;
         if (pending_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: unexpected output item, sample %0d gate %0b", s, g);
            return;
         end
         want = pending_outputs.pop_front();
         if (s !== want.sample || g !== want.gate_open) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: expected sample %0d gate %0b, got sample %0d gate %0b",
                        $signed(want.sample), want.gate_open, s, g);
         end
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction
   endclass

   logic                                     clock = 1'b0;
   logic                                     reset = 1'b1;
   logic                                     req_valid = 1'b0;
   logic                                     req_ready;
   logic                                     req_chan = 1'b0;
   logic signed [ang_pkg::SAMPLE_BITS-1:0]   req_sample_in = '0;
   logic                                     rsp_valid;
   logic                                     rsp_ready = 1'b0;
   logic signed [ang_pkg::SAMPLE_BITS-1:0]   rsp_sample_out;
   logic                                     rsp_gate_is_open;
   logic                                     csr_we = 1'b0;
   logic [ang_pkg::CSR_IDX_BITS-1:0]         csr_index = '0;
   logic [ang_pkg::CSR_DATA_BITS-1:0]        csr_wdata = '0;

   // Percent chance per cycle that the sender holds back or the receiver
   // stalls. Both are changed only between phases.
   int                              sender_idle_pct = 0;
   int                              rsp_stall_pct = 0;
   int                              quiet_cycles = 0;

   gate_scoreboard gate_book = new();

   audio_noise_gate dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_chan         (req_chan),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_gate_is_open (rsp_gate_is_open),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides at every falling edge whether it takes an output
   // item at the next rising edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Both channels are observed at the rising edge, before the block's own
   // registers update, so accepted items are seen exactly as the block sees
   // them. Inputs are noted first so that an input and an output in the same
   // cycle are handled in a fixed order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            gate_book.note_input(req_chan, req_sample_in);
         if (rsp_valid && rsp_ready)
            gate_book.check_result(rsp_sample_out, rsp_gate_is_open);
      end
   end

   // Any cycle that moves an item or writes a register counts as progress.
   // A long run of cycles without progress means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offers one sample item, with random idle cycles ahead of it, and holds
   // it until the block accepts it.
   task automatic send_item(input logic ch,
                            input logic signed [ang_pkg::SAMPLE_BITS-1:0] s);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_chan      <= ch;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every predicted output item has come out,
   // which also means the pipeline is empty.
   task automatic wait_for_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (gate_book.pending() != 0) @(posedge clock);
   endtask

   // One register write, only ever issued while the block is idle.
   task automatic write_csr(input logic [ang_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [ang_pkg::CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      gate_book.set_register(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int                                     burst_left;
      int                                     burst_bits;
      int                                     lvl_bits;
      logic                                   ch;
      logic signed [ang_pkg::SAMPLE_BITS-1:0] s;
      logic [ang_pkg::COEF_BITS-1:0]          att;
      logic [ang_pkg::COEF_BITS-1:0]          rel;
      logic [ang_pkg::LEVEL_BITS-1:0]         cls;
      logic [ang_pkg::LEVEL_BITS-1:0]         opn;
      logic [ang_pkg::HOLD_BITS-1:0]          hld;
      logic [ang_pkg::MIX_BITS-1:0]           mix;

      burst_left = 0;
      burst_bits = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: slow envelope, closed gates; all but channel 0's last item is
      // attenuated. The most negative sample hits an exact rounding tie.
      send_item(1'b0, 24'sd0);
      send_item(1'b0, 24'sd8388607);
      send_item(1'b1, -24'sd8388608);
      send_item(1'b0, -24'sd8388608);
      send_item(1'b1, 24'sd1);
      send_item(1'b0, -24'sd1);
      wait_for_outputs();

      // Instant envelope and zero hold. Writes outside the register list must
      // change nothing, and bits above each register's width are dropped, so
      // the hold lands on zero and the mix above one.
      write_csr(CSR_SPARE_LO, 24'hFFFFFF);
      write_csr(CSR_SPARE_HI, 24'h123456);
      write_csr(ang_pkg::CSR_ATTACK, 24'd0);
      write_csr(ang_pkg::CSR_RELEASE, 24'd0);
      write_csr(ang_pkg::CSR_CLOSE, 24'd1000);
      write_csr(ang_pkg::CSR_OPEN, 24'd2000);
      write_csr(ang_pkg::CSR_HOLD, 24'hFC0000);
      write_csr(ang_pkg::CSR_MIX, 24'hFFFFFF);
      // Channel 0 is still open with hold left from before, so it stays open.
      send_item(1'b0, 24'sd5000);
      send_item(1'b0, 24'sd5000);
      send_item(1'b0, 24'sd0);
      send_item(1'b0, -24'sd8388608);
      // Channel 1 opens, sits between the thresholds, then drops below.
      send_item(1'b1, -24'sd3000);
      send_item(1'b1, 24'sd1500);
      send_item(1'b1, 24'sd999);
      send_item(1'b1, -24'sd999);
      wait_for_outputs();

      // Slowest envelope, thresholds at zero, fully dry output.
      write_csr(ang_pkg::CSR_ATTACK, 24'hFFFFFF);
      write_csr(ang_pkg::CSR_RELEASE, 24'hFFFFFF);
      write_csr(ang_pkg::CSR_CLOSE, 24'd0);
      write_csr(ang_pkg::CSR_OPEN, 24'd0);
      write_csr(ang_pkg::CSR_HOLD, 24'd3);
      write_csr(ang_pkg::CSR_MIX, 24'd0);
      send_item(1'b0, 24'sd8388607);
      send_item(1'b0, 24'sd8388607);
      send_item(1'b0, 24'sd8388607);
      send_item(1'b1, -24'sd8388608);
      send_item(1'b1, -24'sd8388608);
      send_item(1'b1, -24'sd8388608);
      send_item(1'b0, 24'sd2);
      send_item(1'b1, -24'sd2);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_outputs();

         // The first two phases put every register at its top and bottom;
         // the rest pick settings that let the gates open and close within
         // a phase. Random junk fills the bits above the width of each narrower register.
         case (phase)
            0: begin
               att = '1; rel = '1; cls = '1; opn = '1; hld = '1; mix = '1;
            end
            1: begin
               att = '0; rel = '0; cls = '0; opn = '0; hld = '0; mix = '0;
            end
            default: begin
               att = ($urandom_range(7) == 0) ? '1
                     : ang_pkg::COEF_BITS'($urandom_range(0, 24'hF00000));
               rel = ($urandom_range(7) == 0) ? '1
                     : ang_pkg::COEF_BITS'($urandom_range(0, 24'hF00000));
               lvl_bits = $urandom_range(4, ang_pkg::LEVEL_BITS);
               opn = ang_pkg::LEVEL_BITS'($urandom_range(0, (1 << lvl_bits) - 1));
               if ($urandom_range(3) == 0)
                  cls = ang_pkg::LEVEL_BITS'($urandom_range(0, (1 << lvl_bits) - 1));
               else
                  cls = ang_pkg::LEVEL_BITS'($urandom_range(0, opn));
               case ($urandom_range(9))
                  0:       hld = '0;
                  1:       hld = '1;
                  8, 9:    hld = ang_pkg::HOLD_BITS'($urandom_range(0, 200));
                  default: hld = ang_pkg::HOLD_BITS'($urandom_range(1, 12));
               endcase
               case ($urandom_range(5))
                  0:       mix = '0;
                  1:       mix = ang_pkg::MIX_ONE;
                  2:       mix = ang_pkg::MIX_BITS'($urandom_range(ang_pkg::MIX_ONE + 1,
                                                   (1 << ang_pkg::MIX_BITS) - 1));
                  default: mix = ang_pkg::MIX_BITS'($urandom_range(0, ang_pkg::MIX_ONE));
               endcase
            end
         endcase
         write_csr(ang_pkg::CSR_ATTACK, att);
         write_csr(ang_pkg::CSR_RELEASE, rel);
         write_csr(ang_pkg::CSR_CLOSE, {1'($urandom), cls});
         write_csr(ang_pkg::CSR_OPEN, {1'($urandom), opn});
         write_csr(ang_pkg::CSR_HOLD, {6'($urandom), hld});
         write_csr(ang_pkg::CSR_MIX, {7'($urandom), mix});

         // Rotate through no idling, an idle sender, a stalling receiver and
         // both at once.
         case (phase % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin sender_idle_pct = 26; rsp_stall_pct = 26; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Once mid-phase the sender holds off until the block is empty.
            if (phase == 4 && n == PHASE_ITEMS / 2)
               wait_for_outputs();

            // Samples come in bursts of one loudness so that envelopes climb
            // past the open threshold and decay below the close threshold.
            // Some items are full-range noise regardless of the burst.
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               burst_bits = $urandom_range(0, ang_pkg::SAMPLE_BITS);
            end
            burst_left--;
            ch = 1'($urandom_range(1));
            if (burst_bits == ang_pkg::SAMPLE_BITS || $urandom_range(9) == 0) begin
               s = ang_pkg::SAMPLE_BITS'($urandom);
            end else begin
               s = ang_pkg::SAMPLE_BITS'($urandom_range(0, (1 << burst_bits) - 1));
               if ($urandom_range(1) == 1)
                  s = -s;
            end
            send_item(ch, s);
         end
      end

      wait_for_outputs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (gate_book.mismatches == 0 && gate_book.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ang_pkg.sv
hw/rtl/ang_chan_update.sv
hw/rtl/ang_mix.sv
hw/rtl/audio_noise_gate.sv
sim/tb.sv
